// ----- src/mca_pkg.sv -----
// Package: command codes, sequencer types and shared constants for the ALU.
package mca_pkg;

  typedef enum logic [4:0] {
    CMD_MOV = 5'd0, CMD_CMP = 5'd1, CMD_ADD = 5'd2, CMD_SUB = 5'd3,
    CMD_BIT = 5'd4, CMD_BIC = 5'd5, CMD_BIS = 5'd6, CMD_XOR = 5'd7,
    CMD_MUL = 5'd8, CMD_DIV = 5'd9, CMD_ASH = 5'd10, CMD_ASHC = 5'd11,
    CMD_CLR = 5'd12, CMD_COM = 5'd13, CMD_INC = 5'd14, CMD_DEC = 5'd15,
    CMD_NEG = 5'd16, CMD_TST = 5'd17, CMD_ASR = 5'd18, CMD_ASL = 5'd19,
    CMD_ROR = 5'd20, CMD_ROL = 5'd21, CMD_SWAB = 5'd22, CMD_ADC = 5'd23,
    CMD_SBC = 5'd24, CMD_SXT = 5'd25, CMD_BR = 5'd26, CMD_FLAG = 5'd27,
    CMD_U28 = 5'd28, CMD_U29 = 5'd29, CMD_U30 = 5'd30, CMD_U31 = 5'd31
  } cmd_t;

  typedef enum logic [3:0] {
    BR_AL = 4'd0, BR_NE = 4'd1, BR_EQ = 4'd2, BR_PL = 4'd3, BR_MI = 4'd4,
    BR_VC = 4'd5, BR_VS = 4'd6, BR_CC = 4'd7, BR_CS = 4'd8, BR_GE = 4'd9,
    BR_LT = 4'd10, BR_GT = 4'd11, BR_LE = 4'd12, BR_HI = 4'd13, BR_LOS = 4'd14,
    BR_NV = 4'd15
  } brc_t;

  localparam logic [1:0] WB_NONE = 2'd0;
  localparam logic [1:0] WB_ONE  = 2'd1;
  localparam logic [1:0] WB_BOTH = 2'd2;

  localparam logic [5:0]  CNT_MASK = 6'h3F;
  localparam logic [15:0] WMAX     = 16'h7FFF;
  localparam logic [15:0] WSIGN    = 16'h8000;
  localparam logic [7:0]  BMAX     = 8'h7F;
  localparam logic [7:0]  BSIGN    = 8'h80;

  // Sequential unit operation kinds
  typedef enum logic [1:0] {
    SEQ_MUL = 2'd0, SEQ_DIV = 2'd1, SEQ_SHL = 2'd2, SEQ_SHR = 2'd3
  } seq_op_t;

  // Start request to the shared unit
  typedef struct packed {
    seq_op_t     op;
    logic [31:0] acc;     // multiplicand / dividend magnitude / shift value
    logic [15:0] opnd;    // multiplier or divisor magnitude
    logic [5:0]  count;   // step count
  } seq_req_t;

  // Result of the shared unit
  typedef struct packed {
    logic        done;
    logic [31:0] value;   // product, or quotient high / remainder low, or shifted
    logic        last_out;// last bit shifted out
  } seq_rsp_t;

endpackage

// ----- src/minicomputer_alu_with_condition_codes.sv -----
// Top level: sixteen-bit ALU with condition codes and sequenced EIS unit.
//
//  channel | ports        | direction | word contents
//  --------+--------------+-----------+-----------------------------------
//  input   | in_t*        | slave     | one instruction with operands
//  result  | out_t*       | master    | write-back words, pc, flags
//
// Simple operations pass from accept through decode into the output register.
// Multiply takes 16 steps of the shared shift-add unit, divide 16 steps of
// the restoring divider, shifts one step per bit of count (up to 32).
// Reset clears the flags and the sequencer. in_tready is low while an item is
// at work or its result has not been taken.
module minicomputer_alu_with_condition_codes (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata, low bit up: command[4:0], byte_mode[5], src_value[21:6],
  // dst_value[37:22], low_register_value[53:38], odd_register[54],
  // branch_condition[58:55], branch_offset[66:59], pc_value[82:67],
  // flag_mask[86:83], flag_set[87]
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata, low bit up: result_value[15:0], result_low[31:16],
  // write_back[33:32], next_pc[49:34], branch_taken[50], flag_n[51],
  // flag_z[52], flag_v[53], flag_c[54], illegal[55]
  output logic [55:0] out_tdata
);
  import mca_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_RUN = 4'b0010, ST_FIN = 4'b0100, ST_OUT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // latched instruction
  cmd_t        cmd_r;
  logic        byte_r, odd_r, fset_r;
  logic [15:0] src_r, dst_r, lo_r, pc_r;
  logic [3:0]  cond_r, fmask_r;
  logic [7:0]  off_r;
  logic        n_r, z_r, v_r, c_r;
  logic        dsgn_r, qsgn_r;   // dividend sign, quotient sign / product sign
  logic        dovf_r;           // dividend high word already >= divisor
  logic [55:0] out_r, out_nxt;
  logic        n_nxt, z_nxt, v_nxt, c_nxt;

  seq_req_t req;
  seq_rsp_t rsp;
  logic     start;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = out_r;

  mca_seq_unit u_seq (.clk(clk), .rst_n(rst_n), .start(start), .req(req), .rsp(rsp));

  // fields of the accepted word
  cmd_t        i_cmd;
  logic [15:0] i_src, i_dst, i_lo;
  logic        i_odd;
  assign i_cmd = cmd_t'(in_tdata[4:0]);
  assign i_src = in_tdata[21:6];
  assign i_dst = in_tdata[37:22];
  assign i_lo  = in_tdata[53:38];
  assign i_odd = in_tdata[54];

  logic        accept, uses_seq;
  logic [31:0] i_dvd, i_dvd_mag, i_shv;
  logic [15:0] i_src_mag, i_dst_mag;
  logic [5:0]  i_cnt, i_neg_cnt;

  assign accept    = in_tvalid && in_tready;
  assign i_dvd     = {i_dst, i_lo};
  assign i_dvd_mag = i_dvd[31] ? (32'd0 - i_dvd) : i_dvd;
  assign i_src_mag = i_src[15] ? (16'd0 - i_src) : i_src;
  assign i_dst_mag = i_dst[15] ? (16'd0 - i_dst) : i_dst;
  assign i_cnt     = i_src[5:0] & CNT_MASK;
  assign i_neg_cnt = 6'd0 - i_cnt;
  assign uses_seq  = (i_cmd == CMD_MUL) || (i_cmd == CMD_ASH) || (i_cmd == CMD_ASHC) ||
                     ((i_cmd == CMD_DIV) && !i_odd && (i_src != 16'd0));

  always_comb begin
    // ash left works in the top half so bits carry out of bit 31; ash right
    // works sign-extended in the bottom half so bits leave through bit 0
    if (i_cmd == CMD_ASHC) begin
      i_shv = {i_dst, (i_odd ? i_dst : i_lo)};
    end else if (i_cnt[5]) begin
      i_shv = {{16{i_dst[15]}}, i_dst};
    end else begin
      i_shv = {i_dst, 16'd0};
    end
    req.acc   = 32'd0;
    req.opnd  = 16'd0;
    req.count = 6'd0;
    req.op    = SEQ_MUL;
    unique case (i_cmd)
      CMD_MUL: begin
        req.acc = {16'd0, i_dst_mag}; req.opnd = i_src_mag; req.count = 6'd16;
      end
      CMD_DIV: begin
        req.op = SEQ_DIV; req.acc = i_dvd_mag; req.opnd = i_src_mag; req.count = 6'd16;
      end
      default: begin
        req.acc = i_shv;
        if (i_cnt[5]) begin
          req.op = SEQ_SHR; req.count = i_neg_cnt;
        end else begin
          req.op = SEQ_SHL; req.count = i_cnt;
        end
      end
    endcase
  end
  assign start = accept && uses_seq;

  // combinational datapath and finish of sequenced ops
  logic [15:0] m, sb, a, d, r, rv, rl, npc, offx;
  logic [16:0] t;
  logic [1:0]  wb;
  logic        taken, ill, go;
  logic [31:0] prod, qv, shres, val;
  logic [15:0] q16, rem16;
  logic        qovf;
  logic [3:0]  fl;

  always_comb begin
    m  = byte_r ? 16'h00FF : 16'hFFFF;
    sb = byte_r ? {8'd0, BSIGN} : WSIGN;
    a  = src_r & m;
    d  = dst_r & m;
    n_nxt = n_r; z_nxt = z_r; v_nxt = v_r; c_nxt = c_r;
    r = 16'd0; rv = 16'd0; rl = 16'd0; wb = WB_NONE; npc = pc_r;
    taken = 1'b0; ill = 1'b0; go = 1'b0; t = 17'd0;
    offx = {{8{off_r[7]}}, off_r};
    prod = qsgn_r ? (32'd0 - rsp.value) : rsp.value;
    q16  = qsgn_r ? (16'd0 - rsp.value[31:16]) : rsp.value[31:16];
    rem16 = dsgn_r ? (16'd0 - rsp.value[15:0]) : rsp.value[15:0];
    qv = 32'd0;
    qovf = 1'b0;
    shres = 32'd0;
    val = 32'd0;
    fl = 4'd0;
    unique case (cmd_r)
      CMD_MOV, CMD_CMP, CMD_ADD, CMD_SUB, CMD_BIT, CMD_BIC, CMD_BIS, CMD_XOR,
      CMD_CLR, CMD_COM, CMD_INC, CMD_DEC, CMD_NEG, CMD_TST, CMD_ASR, CMD_ASL,
      CMD_ROR, CMD_ROL, CMD_ADC, CMD_SBC: begin
        case (cmd_r)
          CMD_MOV: begin r = a; v_nxt = 1'b0; wb = WB_ONE; end
          CMD_CMP: begin
            r = (a - d) & m; c_nxt = a < d;
            v_nxt = ((a ^ d) & (a ^ r) & sb) != 16'd0;
          end
          CMD_ADD: begin
            t = {1'b0, a} + {1'b0, d}; r = t[15:0] & m; c_nxt = t > {1'b0, m};
            v_nxt = (~(a ^ d) & (a ^ r) & sb) != 16'd0; wb = WB_ONE;
          end
          CMD_SUB: begin
            r = (d - a) & m; c_nxt = d < a;
            v_nxt = ((d ^ a) & (d ^ r) & sb) != 16'd0; wb = WB_ONE;
          end
          CMD_BIT: begin r = a & d; v_nxt = 1'b0; end
          CMD_BIC: begin r = ~a & d & m; v_nxt = 1'b0; wb = WB_ONE; end
          CMD_BIS: begin r = a | d; v_nxt = 1'b0; wb = WB_ONE; end
          CMD_XOR: begin r = a ^ d; v_nxt = 1'b0; wb = WB_ONE; end
          CMD_CLR: begin r = 16'd0; v_nxt = 1'b0; c_nxt = 1'b0; wb = WB_ONE; end
          CMD_COM: begin r = ~d & m; v_nxt = 1'b0; c_nxt = 1'b1; wb = WB_ONE; end
          CMD_INC: begin r = (d + 16'd1) & m; v_nxt = r == sb; wb = WB_ONE; end
          CMD_DEC: begin r = (d - 16'd1) & m; v_nxt = d == sb; wb = WB_ONE; end
          CMD_NEG: begin
            r = (16'd0 - d) & m; v_nxt = r == sb; c_nxt = r != 16'd0; wb = WB_ONE;
          end
          CMD_TST: begin r = d; v_nxt = 1'b0; c_nxt = 1'b0; end
          CMD_ASR: begin
            r = (d >> 1) | (d & sb); c_nxt = d[0];
            v_nxt = ((r & sb) != 16'd0) != c_nxt; wb = WB_ONE;
          end
          CMD_ASL: begin
            r = (d << 1) & m; c_nxt = (d & sb) != 16'd0;
            v_nxt = ((r & sb) != 16'd0) != c_nxt; wb = WB_ONE;
          end
          CMD_ROR: begin
            r = (d >> 1) | (c_r ? sb : 16'd0); c_nxt = d[0];
            v_nxt = ((r & sb) != 16'd0) != c_nxt; wb = WB_ONE;
          end
          CMD_ROL: begin
            r = ((d << 1) & m) | {15'd0, c_r}; c_nxt = (d & sb) != 16'd0;
            v_nxt = ((r & sb) != 16'd0) != c_nxt; wb = WB_ONE;
          end
          CMD_ADC: begin
            r = (d + {15'd0, c_r}) & m;
            v_nxt = c_r && (d == (sb - 16'd1)); c_nxt = c_r && (d == m); wb = WB_ONE;
          end
          default: begin
            r = (d - {15'd0, c_r}) & m;
            v_nxt = c_r && (d == sb); c_nxt = c_r && (d == 16'd0); wb = WB_ONE;
          end
        endcase
        n_nxt = (r & sb) != 16'd0;
        z_nxt = r == 16'd0;
        if (wb != WB_NONE) rv = (dst_r & ~m) | (r & m);
      end
      CMD_MUL: begin
        n_nxt = prod[31]; z_nxt = prod == 32'd0; v_nxt = 1'b0;
        c_nxt = (prod[31:15] != 17'd0) && (prod[31:15] != 17'h1FFFF);
        if (odd_r) begin
          rv = prod[15:0]; wb = WB_ONE;
        end else begin
          rv = prod[31:16]; rl = prod[15:0]; wb = WB_BOTH;
        end
      end
      CMD_DIV: begin
        if (odd_r) begin
          ill = 1'b1;
        end else if (src_r == 16'd0) begin
          n_nxt = 1'b0; z_nxt = 1'b0; v_nxt = 1'b1; c_nxt = 1'b1;
        end else begin
          // a high word at or above the divisor gives a quotient past 16 bits;
          // otherwise the magnitude must fit 15 bits, or be 0x8000 when negative
          qovf = dovf_r ||
                 (rsp.value[31] && !(qsgn_r && (rsp.value[31:16] == WSIGN)));
          if (qovf) begin
            n_nxt = 1'b0; z_nxt = 1'b0; v_nxt = 1'b1; c_nxt = 1'b0;
          end else begin
            rv = q16; rl = rem16; wb = WB_BOTH;
            n_nxt = q16[15]; z_nxt = q16 == 16'd0; v_nxt = 1'b0; c_nxt = 1'b0;
          end
        end
      end
      CMD_ASH: begin
        shres = {16'd0, (src_r[5] ? rsp.value[15:0] : rsp.value[31:16])};
        c_nxt = rsp.last_out;
        n_nxt = shres[15]; z_nxt = shres[15:0] == 16'd0;
        v_nxt = shres[15] != dst_r[15];
        rv = shres[15:0]; wb = WB_ONE;
      end
      CMD_ASHC: begin
        shres = rsp.value;
        val = {dst_r, (odd_r ? dst_r : lo_r)};
        c_nxt = rsp.last_out;
        n_nxt = shres[31]; z_nxt = shres == 32'd0;
        v_nxt = shres[31] != val[31];
        if (odd_r) begin
          rv = shres[15:0]; wb = WB_ONE;
        end else begin
          rv = shres[31:16]; rl = shres[15:0]; wb = WB_BOTH;
        end
      end
      CMD_SWAB: begin
        rv = {dst_r[7:0], dst_r[15:8]}; wb = WB_ONE;
        n_nxt = rv[7]; z_nxt = rv[7:0] == 8'd0; v_nxt = 1'b0; c_nxt = 1'b0;
      end
      CMD_SXT: begin
        rv = n_r ? 16'hFFFF : 16'd0; wb = WB_ONE; z_nxt = !n_r; v_nxt = 1'b0;
      end
      CMD_BR: begin
        unique case (brc_t'(cond_r))
          BR_AL:  go = 1'b1;
          BR_NE:  go = !z_r;
          BR_EQ:  go = z_r;
          BR_PL:  go = !n_r;
          BR_MI:  go = n_r;
          BR_VC:  go = !v_r;
          BR_VS:  go = v_r;
          BR_CC:  go = !c_r;
          BR_CS:  go = c_r;
          BR_GE:  go = n_r == v_r;
          BR_LT:  go = n_r != v_r;
          BR_GT:  go = (n_r == v_r) && !z_r;
          BR_LE:  go = (n_r != v_r) || z_r;
          BR_HI:  go = !c_r && !z_r;
          BR_LOS: go = c_r || z_r;
          default: go = 1'b0;
        endcase
        if (go) begin
          npc = pc_r + {offx[14:0], 1'b0}; taken = 1'b1;
        end
      end
      CMD_FLAG: begin
        fl = fset_r ? ({n_r, z_r, v_r, c_r} | fmask_r) : ({n_r, z_r, v_r, c_r} & ~fmask_r);
        {n_nxt, z_nxt, v_nxt, c_nxt} = fl;
      end
      default: begin
      end
    endcase
    out_nxt = {ill, c_nxt, v_nxt, z_nxt, n_nxt, taken, npc, wb, rl, rv};
  end

  // sequencer: latch, run shared unit, finish into output register
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = uses_seq ? ST_RUN : ST_FIN;
      ST_RUN:  if (rsp.done) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_OUT;
      ST_OUT:  if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic finish;
  assign finish = (state_r == ST_FIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      n_r <= 1'b0; z_r <= 1'b0; v_r <= 1'b0; c_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        n_r <= n_nxt; z_r <= z_nxt; v_r <= v_nxt; c_r <= c_nxt;
      end
    end
    if (accept) begin
      cmd_r   <= i_cmd;
      byte_r  <= in_tdata[5];
      src_r   <= i_src;
      dst_r   <= i_dst;
      lo_r    <= i_lo;
      odd_r   <= i_odd;
      cond_r  <= in_tdata[58:55];
      off_r   <= in_tdata[66:59];
      pc_r    <= in_tdata[82:67];
      fmask_r <= in_tdata[86:83];
      fset_r  <= in_tdata[87];
      dsgn_r  <= i_dst[15];
      qsgn_r  <= i_dst[15] ^ i_src[15];
      dovf_r  <= (i_dvd_mag[31:16] >= i_src_mag);
    end
    if (finish) out_r <= out_nxt;
  end

  // hold the result word while stalled
  property p_hold;
    @(posedge clk) disable iff (!rst_n) (out_tvalid && !out_tready) |=> $stable(out_tdata);
  endproperty
  a_hold: assert property (p_hold) else $error("result word changed under stall");

  // never accept while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  // a result follows only a finish step
  a_fin: assert property (@(posedge clk) disable iff (!rst_n) $rose(out_tvalid) |-> $past(finish))
    else $error("result without finish");

endmodule

// ----- src/mca_seq_unit.sv -----
// Shared iterative unit: shift-add multiply, restoring divide, one-bit shifts.
module mca_seq_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mca_pkg::seq_req_t req,
  output mca_pkg::seq_rsp_t rsp
);
  import mca_pkg::*;

  seq_op_t     op_r;
  logic [31:0] acc_r, acc_nxt;     // product/remainder or shift value
  logic [31:0] aux_r, aux_nxt;     // multiplier shifter / dividend bits
  logic [16:0] opnd_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        out_r, out_nxt;
  logic [16:0] trial;
  logic [16:0] rem_sh;

  always_comb begin
    acc_nxt  = acc_r;
    aux_nxt  = aux_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    out_nxt  = out_r;
    rem_sh   = {acc_r[15:0], aux_r[31]};
    trial    = rem_sh - opnd_r;
    if (busy_r) begin
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
        unique case (op_r)
          SEQ_MUL: begin
            // add shifted multiplicand when multiplier bit is set
            if (aux_r[0]) acc_nxt = acc_r + {aux_r[31:16], 16'd0};
            aux_nxt = {aux_r[31:16], 1'b0, aux_r[15:1]};
            acc_nxt = {1'b0, acc_nxt[31:1]};
          end
          SEQ_DIV: begin
            aux_nxt = {aux_r[30:0], 1'b0};
            if (!trial[16]) begin
              acc_nxt = {acc_r[31:16], trial[15:0]};
              acc_nxt[31:16] = {acc_r[30:16], 1'b1};
            end else begin
              acc_nxt = {acc_r[30:16], 1'b0, rem_sh[15:0]};
            end
          end
          SEQ_SHL: begin
            out_nxt = acc_r[31];
            acc_nxt = {acc_r[30:0], 1'b0};
          end
          default: begin
            out_nxt = acc_r[0];
            acc_nxt = {acc_r[31], acc_r[31:1]};
          end
        endcase
      end
    end
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.count;
      out_nxt  = 1'b0;
      if (req.op == SEQ_MUL) begin
        acc_nxt = 32'd0;
        aux_nxt = {req.acc[15:0], req.opnd};
      end else if (req.op == SEQ_DIV) begin
        acc_nxt = {16'd0, req.acc[31:16]};
        aux_nxt = {req.acc[15:0], 16'd0};
      end else begin
        acc_nxt = req.acc;
        aux_nxt = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    acc_r <= acc_nxt;
    aux_r <= aux_nxt;
    cnt_r <= cnt_nxt;
    out_r <= out_nxt;
    if (start) begin
      op_r   <= req.op;
      opnd_r <= {1'b0, req.opnd};
    end
  end

  // Multiply: 16 steps each add then shift right; product ends in acc.
  assign rsp.done     = busy_r && (cnt_r == 6'd0);
  assign rsp.value    = acc_r;
  assign rsp.last_out = out_r;

endmodule

// ----- bench/minicomputer_alu_with_condition_codes_test.sv -----
// Testbench for the sixteen-bit ALU: predicts each result word and checks it field by field.
`timescale 1ns / 100ps

module minicomputer_alu_with_condition_codes_test;
  import mca_pkg::*;

  typedef struct packed {
    logic        flag_set;
    logic [3:0]  flag_mask;
    logic [15:0] pc_value;
    logic [7:0]  branch_offset;
    logic [3:0]  branch_condition;
    logic        odd_register;
    logic [15:0] low_register_value;
    logic [15:0] dst_value;
    logic [15:0] src_value;
    logic        byte_mode;
    logic [4:0]  command;
  } instr_t;

  typedef struct packed {
    logic        illegal;
    logic        flag_c;
    logic        flag_v;
    logic        flag_z;
    logic        flag_n;
    logic        branch_taken;
    logic [15:0] next_pc;
    logic [1:0]  write_back;
    logic [15:0] result_low;
    logic [15:0] result_value;
  } outcome_t;

  localparam int STALL_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;

  instr_t   pending_instrs[$];
  outcome_t expected_outcomes[$];
  logic [3:0] nzvc;        // predicted flags: bit0 C, bit1 V, bit2 Z, bit3 N
  int       send_idle_pct;
  int       recv_idle_pct;
  int       error_count;
  int       quiet_cycles;
  bit       stim_done;

  minicomputer_alu_with_condition_codes u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Execute one instruction against the predicted flags and advance them.
  function automatic outcome_t execute_instr(instr_t it);
    outcome_t o;
    logic n, z, v, c, bm;
    logic [15:0] m, sb, a, d, r;
    logic [16:0] t;
    logic signed [31:0] p;
    logic signed [63:0] x, y, q, rem;
    logic [63:0] val, res, u, w;
    logic [5:0] cnt;
    int k, width;
    logic [15:0] so;
    logic go;
    logic [3:0] f;
    cmd_t cmd;
    n = nzvc[3]; z = nzvc[2]; v = nzvc[1]; c = nzvc[0];
    o = '0;
    o.next_pc = it.pc_value;
    cmd = cmd_t'(it.command);
    bm = it.byte_mode;
    m  = bm ? 16'h00FF : 16'hFFFF;
    sb = bm ? 16'h0080 : 16'h8000;
    a = it.src_value & m;
    d = it.dst_value & m;
    r = '0;
    case (cmd)
      CMD_MOV, CMD_CMP, CMD_ADD, CMD_SUB, CMD_BIT, CMD_BIC, CMD_BIS, CMD_XOR,
      CMD_CLR, CMD_COM, CMD_INC, CMD_DEC, CMD_NEG, CMD_TST, CMD_ASR, CMD_ASL,
      CMD_ROR, CMD_ROL, CMD_ADC, CMD_SBC: begin
        case (cmd)
          CMD_MOV: begin r = a; v = 0; o.write_back = WB_ONE; end
          CMD_CMP: begin
            r = (a - d) & m; c = a < d; v = ((a ^ d) & (a ^ r) & sb) != 0;
          end
          CMD_ADD: begin
            t = a + d; r = t[15:0] & m; c = t > m;
            v = (~(a ^ d) & (a ^ r) & sb) != 0; o.write_back = WB_ONE;
          end
          CMD_SUB: begin
            r = (d - a) & m; c = d < a; v = ((d ^ a) & (d ^ r) & sb) != 0;
            o.write_back = WB_ONE;
          end
          CMD_BIT: begin r = a & d; v = 0; end
          CMD_BIC: begin r = ~a & d & m; v = 0; o.write_back = WB_ONE; end
          CMD_BIS: begin r = a | d; v = 0; o.write_back = WB_ONE; end
          CMD_XOR: begin r = a ^ d; v = 0; o.write_back = WB_ONE; end
          CMD_CLR: begin r = 0; v = 0; c = 0; o.write_back = WB_ONE; end
          CMD_COM: begin r = ~d & m; v = 0; c = 1; o.write_back = WB_ONE; end
          CMD_INC: begin r = (d + 16'd1) & m; v = r == sb; o.write_back = WB_ONE; end
          CMD_DEC: begin r = (d - 16'd1) & m; v = d == sb; o.write_back = WB_ONE; end
          CMD_NEG: begin
            r = (16'd0 - d) & m; v = r == sb; c = r != 0; o.write_back = WB_ONE;
          end
          CMD_TST: begin r = d; v = 0; c = 0; end
          CMD_ASR: begin
            r = (d >> 1) | (d & sb); c = d[0];
            v = ((r & sb) != 0) != c; o.write_back = WB_ONE;
          end
          CMD_ASL: begin
            r = (d << 1) & m; c = (d & sb) != 0;
            v = ((r & sb) != 0) != c; o.write_back = WB_ONE;
          end
          CMD_ROR: begin
            r = (d >> 1) | (c ? sb : 16'h0); c = d[0];
            v = ((r & sb) != 0) != c; o.write_back = WB_ONE;
          end
          CMD_ROL: begin
            r = ((d << 1) & m) | {15'h0, c}; c = (d & sb) != 0;
            v = ((r & sb) != 0) != c; o.write_back = WB_ONE;
          end
          CMD_ADC: begin
            r = (d + {15'h0, c}) & m; v = c && d == sb - 16'd1; c = c && d == m;
            o.write_back = WB_ONE;
          end
          default: begin
            r = (d - {15'h0, c}) & m; v = c && d == sb; c = c && d == 0;
            o.write_back = WB_ONE;
          end
        endcase
        n = (r & sb) != 0;
        z = r == 0;
        if (o.write_back != WB_NONE) o.result_value = (it.dst_value & ~m) | (r & m);
      end
      CMD_MUL: begin
        p = $signed(it.dst_value) * $signed(it.src_value);
        n = p < 0; z = p == 0; v = 0; c = p < -32768 || p > 32767;
        if (it.odd_register) begin
          o.result_value = p[15:0]; o.write_back = WB_ONE;
        end else begin
          o.result_value = p[31:16]; o.result_low = p[15:0];
          o.write_back = WB_BOTH;
        end
      end
      CMD_DIV: begin
        if (it.odd_register) begin
          o.illegal = 1;
        end else if (it.src_value == 0) begin
          n = 0; z = 0; v = 1; c = 1;
        end else begin
          x = $signed({it.dst_value, it.low_register_value});
          y = $signed(it.src_value);
          q = x / y; rem = x % y;
          if (q < -32768 || q > 32767) begin
            n = 0; z = 0; v = 1; c = 0;
          end else begin
            o.result_value = q[15:0]; o.result_low = rem[15:0];
            o.write_back = WB_BOTH;
            n = q < 0; z = q == 0; v = 0; c = 0;
          end
        end
      end
      CMD_ASH, CMD_ASHC: begin
        cnt = it.src_value[5:0];
        width = (cmd == CMD_ASHC) ? 32 : 16;
        if (cmd == CMD_ASHC)
          val = {32'h0, it.dst_value,
                 it.odd_register ? it.dst_value : it.low_register_value};
        else
          val = {48'h0, it.dst_value};
        if (cnt[5]) begin
          k = 64 - int'(cnt);
          u = val[width-1] ? (val | (~64'h0 << width)) : val;
          c = u[k-1];
          res = (u >> k) & ~(~64'h0 << width);
        end else begin
          w = val << cnt;
          res = w & ~(~64'h0 << width);
          c = cnt != 0 && w[width];
        end
        n = res[width-1];
        z = res == 0;
        v = res[width-1] != val[width-1];
        if (cmd == CMD_ASH) begin
          o.result_value = res[15:0]; o.write_back = WB_ONE;
        end else if (it.odd_register) begin
          o.result_value = res[15:0]; o.write_back = WB_ONE;
        end else begin
          o.result_value = res[31:16]; o.result_low = res[15:0];
          o.write_back = WB_BOTH;
        end
      end
      CMD_SWAB: begin
        o.result_value = {it.dst_value[7:0], it.dst_value[15:8]};
        o.write_back = WB_ONE;
        n = o.result_value[7]; z = o.result_value[7:0] == 0; v = 0; c = 0;
      end
      CMD_SXT: begin
        o.result_value = n ? 16'hFFFF : 16'h0;
        o.write_back = WB_ONE;
        z = !n; v = 0;
      end
      CMD_BR: begin
        case (brc_t'(it.branch_condition))
          BR_AL:  go = 1;
          BR_NE:  go = !z;
          BR_EQ:  go = z;
          BR_PL:  go = !n;
          BR_MI:  go = n;
          BR_VC:  go = !v;
          BR_VS:  go = v;
          BR_CC:  go = !c;
          BR_CS:  go = c;
          BR_GE:  go = n == v;
          BR_LT:  go = n != v;
          BR_GT:  go = n == v && !z;
          BR_LE:  go = n != v || z;
          BR_HI:  go = !c && !z;
          BR_LOS: go = c || z;
          default: go = 0;
        endcase
        if (go) begin
          so = {{8{it.branch_offset[7]}}, it.branch_offset};
          o.next_pc = it.pc_value + (so << 1);
          o.branch_taken = 1;
        end
      end
      CMD_FLAG: begin
        f = it.flag_set ? (nzvc | it.flag_mask) : (nzvc & ~it.flag_mask);
        n = f[3]; z = f[2]; v = f[1]; c = f[0];
      end
      default: ;
    endcase
    nzvc = {n, z, v, c};
    o.flag_n = n; o.flag_z = z; o.flag_v = v; o.flag_c = c;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    error_count++;
  endtask

  function automatic instr_t random_instr();
    instr_t it;
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    it = instr_t'(bits[87:0]);
    it.command = 5'($urandom_range(0, 31));
    // Keep divides mostly in range: a small high word of either sign, random divisor.
    if (it.command == CMD_DIV && $urandom_range(0, 2) != 0)
      it.dst_value = $urandom_range(0, 1) ? 16'(int'($urandom_range(0, 255)))
                                          : 16'hFFFF - 16'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) it.dst_value = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
    if ($urandom_range(0, 3) == 0) it.dst_value[7:0] = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
    return it;
  endfunction

  function automatic instr_t make_instr(cmd_t cmd, logic bm, logic [15:0] s,
                                        logic [15:0] d);
    instr_t it;
    it = '0;
    it.command = cmd; it.byte_mode = bm; it.src_value = s; it.dst_value = d;
    it.pc_value = 16'h1000;
    return it;
  endfunction

  // Directed opening, then random items in three idling phases.
  initial begin
    instr_t it;
    error_count = 0;
    send_idle_pct = 24;
    recv_idle_pct = 76;
    stim_done = 0;
    nzvc = '0;
    pending_instrs.push_back(make_instr(CMD_ADD, 1'b0, 16'h7FFF, 16'h0001));
    pending_instrs.push_back(make_instr(CMD_ADD, 1'b1, 16'h00FF, 16'hAB01));
    pending_instrs.push_back(make_instr(CMD_CMP, 1'b0, 16'h0000, 16'hFFFF));
    pending_instrs.push_back(make_instr(CMD_SUB, 1'b1, 16'h0001, 16'h1280));
    pending_instrs.push_back(make_instr(CMD_COM, 1'b0, 16'h0, 16'h0000));
    pending_instrs.push_back(make_instr(CMD_NEG, 1'b0, 16'h0, 16'h8000));
    pending_instrs.push_back(make_instr(CMD_ROR, 1'b0, 16'h0, 16'h0001));
    pending_instrs.push_back(make_instr(CMD_ROL, 1'b1, 16'h0, 16'h5580));
    pending_instrs.push_back(make_instr(CMD_SWAB, 1'b0, 16'h0, 16'h12FF));
    pending_instrs.push_back(make_instr(CMD_MUL, 1'b0, 16'h8000, 16'h8000));
    pending_instrs.push_back(make_instr(CMD_MUL, 1'b0, 16'hFFFF, 16'h7FFF));
    it = make_instr(CMD_MUL, 1'b0, 16'h0003, 16'h0005); it.odd_register = 1;
    pending_instrs.push_back(it);
    it = make_instr(CMD_DIV, 1'b0, 16'h0007, 16'hFFFF); it.low_register_value = 16'hFFF0;
    pending_instrs.push_back(it);
    pending_instrs.push_back(make_instr(CMD_DIV, 1'b0, 16'h0000, 16'h0001));
    pending_instrs.push_back(make_instr(CMD_DIV, 1'b0, 16'h0001, 16'h0001));
    pending_instrs.push_back(make_instr(CMD_DIV, 1'b0, 16'hFFFF, 16'hFFFF));
    it = make_instr(CMD_DIV, 1'b0, 16'h0003, 16'h0); it.odd_register = 1;
    pending_instrs.push_back(it);
    pending_instrs.push_back(make_instr(CMD_ASH, 1'b0, 16'h0020, 16'h8001));
    pending_instrs.push_back(make_instr(CMD_ASH, 1'b0, 16'h003F, 16'h0003));
    pending_instrs.push_back(make_instr(CMD_ASH, 1'b0, 16'h001F, 16'h0001));
    it = make_instr(CMD_ASHC, 1'b0, 16'h0021, 16'h8000); it.low_register_value = 16'h0001;
    pending_instrs.push_back(it);
    it = make_instr(CMD_ASHC, 1'b0, 16'h0004, 16'h1234); it.odd_register = 1;
    pending_instrs.push_back(it);
    it = make_instr(CMD_FLAG, 1'b0, 16'h0, 16'h0); it.flag_mask = 4'hF; it.flag_set = 1;
    pending_instrs.push_back(it);
    pending_instrs.push_back(make_instr(CMD_ADC, 1'b1, 16'h0, 16'h00FF));
    it = make_instr(CMD_BR, 1'b0, 16'h0, 16'h0); it.branch_condition = BR_NV;
    it.branch_offset = 8'h80;
    pending_instrs.push_back(it);
    it = make_instr(CMD_BR, 1'b0, 16'h0, 16'h0); it.branch_offset = 8'h80;
    it.pc_value = 16'h0010;
    pending_instrs.push_back(it);
    pending_instrs.push_back(make_instr(CMD_U30, 1'b1, 16'hFFFF, 16'hFFFF));
    for (int i = 0; i < 230; i++) pending_instrs.push_back(random_instr());
    wait (rst_n && pending_instrs.size() == 0);
    send_idle_pct = 76;
    recv_idle_pct = 24;
    for (int i = 0; i < 250; i++) pending_instrs.push_back(random_instr());
    wait (pending_instrs.size() == 0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 250; i++) pending_instrs.push_back(random_instr());
    wait (pending_instrs.size() == 0);
    stim_done = 1;
  end

  // Driver: offer the head of the queue, hold it until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        expected_outcomes.push_back(execute_instr(instr_t'(in_tdata)));
        void'(pending_instrs.pop_front());
      end
      // Decide on the remaining queue after dropping the accepted word.
      if (pending_instrs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_instrs[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = outcome_t'(out_tdata);
        if (expected_outcomes.size() == 0) begin
          report_mismatch("unexpected result", got.result_value, 16'h0);
        end else begin
          want = expected_outcomes.pop_front();
          if (got.result_value != want.result_value)
            report_mismatch("result_value", got.result_value, want.result_value);
          if (got.result_low != want.result_low)
            report_mismatch("result_low", got.result_low, want.result_low);
          if (got.write_back != want.write_back)
            report_mismatch("write_back", got.write_back, want.write_back);
          if (got.next_pc != want.next_pc)
            report_mismatch("next_pc", got.next_pc, want.next_pc);
          if (got.branch_taken != want.branch_taken)
            report_mismatch("branch_taken", got.branch_taken, want.branch_taken);
          if (got.flag_n != want.flag_n) report_mismatch("flag_n", got.flag_n, want.flag_n);
          if (got.flag_z != want.flag_z) report_mismatch("flag_z", got.flag_z, want.flag_z);
          if (got.flag_v != want.flag_v) report_mismatch("flag_v", got.flag_v, want.flag_v);
          if (got.flag_c != want.flag_c) report_mismatch("flag_c", got.flag_c, want.flag_c);
          if (got.illegal != want.illegal)
            report_mismatch("illegal", got.illegal, want.illegal);
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: count cycles with no accepted word on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    fork
      begin
        wait (stim_done && !in_tvalid && expected_outcomes.size() == 0);
        repeat (50) @(posedge clk);
      end
      wait (quiet_cycles >= STALL_LIMIT);
    join_any
    if (quiet_cycles >= STALL_LIMIT || error_count != 0 || expected_outcomes.size() != 0)
      $display("simulation failed");
    else
      $display("simulation ok");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/mca_pkg.sv
src/mca_seq_unit.sv
src/minicomputer_alu_with_condition_codes.sv
bench/minicomputer_alu_with_condition_codes_test.sv
